>>> design/pfad_pkg.sv
// ----------------------------------------------------------------------------
// pfad_pkg: shared definitions for the polyphase FIR downsampler
// Widths, codes, saturation bounds and the sequencer program.
// ----------------------------------------------------------------------------
package pfad_pkg;

	// geometry
	localparam int MAX_TAPS   = 16;
	localparam int PHASES     = 256;
	localparam int BANK_SIZE  = MAX_TAPS * PHASES;
	localparam int BANK_AW    = $clog2(BANK_SIZE);
	localparam int RING_AW    = $clog2(MAX_TAPS);

	// field widths
	localparam int SMP_W      = 16;
	localparam int TAP_W      = 5;
	localparam int RATIO_W    = 23;
	localparam int POS_W      = 32;
	localparam int FRAC_W     = 19;
	localparam int IPOS_W     = POS_W - FRAC_W;
	localparam int SEEN_W     = IPOS_W;
	localparam int PHASE_LSB  = 11;
	localparam int PHASE_W    = $clog2(PHASES);
	localparam int PROD_W     = 2 * SMP_W;
	localparam int ACC_W      = PROD_W + RING_AW;
	localparam int RND_SHIFT  = 14;

	// config port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = RATIO_W;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t CFG_STEP_RATIO = cfg_idx_t'(0);
	localparam cfg_idx_t CFG_TAP_COUNT  = cfg_idx_t'(1);

	localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(23'h100000);
	localparam logic [TAP_W-1:0]   TAPS_RESET  = TAP_W'(4);

	// item opcodes
	typedef logic [0:0] opcode_t;
	localparam opcode_t OP_SAMPLE = 1'b0;
	localparam opcode_t OP_COEF   = 1'b1;

	// saturation / rounding
	localparam logic signed [ACC_W-1:0] ACC_MAX  = ACC_W'(32'sh1fffffff);
	localparam logic signed [ACC_W-1:0] ACC_MIN  = ~ACC_MAX;
	localparam logic signed [ACC_W-1:0] RND_BIAS = ACC_W'(32'sh2000);
	localparam logic signed [ACC_W-1:0] RND_TOP  = ACC_W'(32'sh7fff);
	localparam logic signed [SMP_W-1:0] OUT_MAX  = 16'sh7fff;
	localparam logic signed [SMP_W-1:0] OUT_MIN  = 16'sh8000;

	// sequencer
	localparam int PC_W = 3;
	typedef logic [PC_W-1:0] step_t;
	localparam step_t STEP_FETCH = step_t'(0);
	localparam step_t STEP_CHECK = step_t'(1);
	localparam step_t STEP_MAC   = step_t'(2);
	localparam step_t STEP_DRAIN = step_t'(3);
	localparam step_t STEP_EMIT  = step_t'(4);

	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_SAMPLE_IN,
		COND_WIN_READY,
		COND_TAPS_DONE,
		COND_OUT_FREE
	} cond_t;

	typedef struct packed {
		logic  in_ready;   // take an item this step
		logic  check;      // window test, latch row base, clear accumulator
		logic  issue;      // issue one tap read while taps remain
		logic  emit;       // load output register, advance position
		cond_t cond;
		step_t next_t;     // next step when cond holds
		step_t next_f;     // next step otherwise
	} ucode_t;

	function automatic ucode_t ucode_rom(input step_t pc);
		ucode_t u;
		u = '{in_ready: 1'b0, check: 1'b0, issue: 1'b0, emit: 1'b0,
			cond: COND_ALWAYS, next_t: STEP_FETCH, next_f: STEP_FETCH};
		case (pc)
			STEP_FETCH: begin
				u.in_ready = 1'b1;
				u.cond     = COND_SAMPLE_IN;
				u.next_t   = STEP_CHECK;
				u.next_f   = STEP_FETCH;
			end
			STEP_CHECK: begin
				u.check  = 1'b1;
				u.cond   = COND_WIN_READY;
				u.next_t = STEP_MAC;
				u.next_f = STEP_FETCH;
			end
			STEP_MAC: begin
				u.issue  = 1'b1;
				u.cond   = COND_TAPS_DONE;
				u.next_t = STEP_DRAIN;
				u.next_f = STEP_MAC;
			end
			STEP_DRAIN: begin
				u.cond   = COND_ALWAYS;
				u.next_t = STEP_EMIT;
				u.next_f = STEP_EMIT;
			end
			STEP_EMIT: begin
				u.emit   = 1'b1;
				u.cond   = COND_OUT_FREE;
				u.next_t = STEP_FETCH;
				u.next_f = STEP_EMIT;
			end
			default: begin
				u.cond   = COND_ALWAYS;
				u.next_t = STEP_FETCH;
				u.next_f = STEP_FETCH;
			end
		endcase
		return u;
	endfunction

	// taps above the ring depth act as the ring depth
	function automatic logic [TAP_W-1:0] eff_taps(input logic [TAP_W-1:0] tc);
		return (tc > TAP_W'(MAX_TAPS)) ? TAP_W'(MAX_TAPS) : tc;
	endfunction

endpackage

>>> design/pfad_ifs.sv
// ----------------------------------------------------------------------------
// pfad_ifs: valid/ready channels of the polyphase FIR downsampler
// Input item channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
interface pfad_item_if;
	import pfad_pkg::*;
	logic                    valid;
	logic                    ready;
	logic                    opcode;
	logic signed [SMP_W-1:0] sample;
	logic [BANK_AW-1:0]      coef_index;
	logic signed [SMP_W-1:0] coef_value;

	modport source (output valid, opcode, sample, coef_index, coef_value, input ready);
	modport sink   (input valid, opcode, sample, coef_index, coef_value, output ready);
endinterface

interface pfad_result_if;
	import pfad_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] out_sample;
	logic                    clipped;

	modport source (output valid, out_sample, clipped, input ready);
	modport sink   (input valid, out_sample, clipped, output ready);
endinterface

interface pfad_cfg_if;
	import pfad_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

>>> design/polyphase_fir_audio_downsampler_top.sv
// ----------------------------------------------------------------------------
// polyphase_fir_audio_downsampler_top: 256-phase polyphase FIR downsampler
// Mono 16-bit samples in, filtered and decimated samples out; coefficient
// bank loaded through the same item channel.
// ----------------------------------------------------------------------------
//
//  channel  dir  transaction carries
//  -------  ---  ---------------------------------------------------------
//  item     in   opcode, sample, coef_index, coef_value
//  result   out  out_sample, clipped
//  cfg      in   index (0 step_ratio, 1 tap_count), data
//
//  Timing: the single multiply-accumulate unit takes one tap per cycle. A
//  coefficient write is taken in the fetch step, a sample that completes no
//  window passes fetch and check, an output adds MAC, drain and emit steps.
//  Reset: arst_n clears the control state, history ring, position and count;
//  the coefficient bank holds garbage until written, no clearing pass.
//  Stalls: the result register holds one output; the sequencer waits in its
//  emit step only if a new output is due while the previous one is untaken.
//  cfg is always ready; a write restarts the stream, the bank is kept.
//
module polyphase_fir_audio_downsampler_top (
	input  logic          clk,
	input  logic          arst_n,
	pfad_item_if.sink     item,
	pfad_result_if.source result,
	pfad_cfg_if.sink      cfg
);
	import pfad_pkg::*;

	// ------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------
	step_t  step_q;
	ucode_t uc;
	logic   cond_met;

	// configuration
	logic [RATIO_W-1:0] ratio_q;
	logic [TAP_W-1:0]   taps_cfg_q;
	logic [TAP_W-1:0]   taps;
	logic [TAP_W-1:0]   new_taps_raw;
	logic [SEEN_W-1:0]  restart_seen;
	logic               cfg_acc;

	// stream state
	logic signed [SMP_W-1:0] ring_q [MAX_TAPS];
	logic [SEEN_W-1:0]       seen_q;   // low bits double as ring write pointer
	logic [POS_W-1:0]        pos_q;
	logic [SEEN_W-1:0]       avail;
	logic                    win_ready;

	// item decode
	logic item_acc;
	logic sample_in;
	logic coef_wr;

	// tap loop
	logic [TAP_W-1:0]          t_q;
	logic                      taps_done;
	logic [BANK_AW-1:0]        base_q;
	logic [TAP_W+PHASE_W-1:0]  base_full;
	logic [RING_AW-1:0]        slot0_q;
	logic [RING_AW-1:0]        ring_rd_idx;
	logic [BANK_AW-1:0]        bank_addr;
	logic                      tap_issue;

	// coefficient bank
	logic signed [SMP_W-1:0] bank [BANK_SIZE];

	// MAC pipeline
	logic signed [SMP_W-1:0]  coef_s1;
	logic signed [SMP_W-1:0]  smp_s1;
	logic                     vld_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic                     vld_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// output formatting
	logic signed [ACC_W-1:0] rnd_full;
	logic signed [SMP_W-1:0] res_val;
	logic                    res_clip;
	logic                    out_free;
	logic                    emit_go;

	logic                    out_valid_q;
	logic signed [SMP_W-1:0] out_sample_q;
	logic                    clipped_q;

	// ------------------------------------------------------------------
	// decode and conditions
	// ------------------------------------------------------------------
	assign uc = ucode_rom(step_q);

	assign item.ready = uc.in_ready;
	assign item_acc   = item.valid & item.ready;
	assign sample_in  = item_acc & (item.opcode == OP_SAMPLE);
	assign coef_wr    = item_acc & (item.opcode == OP_COEF);

	assign cfg.ready  = 1'b1;
	assign cfg_acc    = cfg.valid & cfg.ready;

	assign taps = eff_taps(taps_cfg_q);

	// a tap_count write restarts with the new count, any other with the old
	assign new_taps_raw = (cfg_acc && (cfg.index == CFG_TAP_COUNT)) ?
		cfg.data[TAP_W-1:0] : taps_cfg_q;
	assign restart_seen = SEEN_W'(eff_taps(new_taps_raw) >> 1);

	// window test: samples available past the integer position, mod 8192;
	// upper half of that range means the position lies ahead of the input
	assign avail     = seen_q - pos_q[POS_W-1:FRAC_W];
	assign win_ready = ~avail[SEEN_W-1] &&
		(avail[SEEN_W-2:0] >= (SEEN_W-1)'(taps));

	assign taps_done = (t_q == taps);
	assign tap_issue = uc.issue & ~taps_done;

	assign out_free = ~out_valid_q | result.ready;

	always_comb begin
		case (uc.cond)
			COND_ALWAYS:    cond_met = 1'b1;
			COND_SAMPLE_IN: cond_met = sample_in;
			COND_WIN_READY: cond_met = win_ready;
			COND_TAPS_DONE: cond_met = taps_done;
			COND_OUT_FREE:  cond_met = out_free;
			default:        cond_met = 1'b1;
		endcase
	end

	assign emit_go = uc.emit & cond_met;

	// row base = taps * phase, phase from position bits 18:11
	assign base_full   = taps * pos_q[PHASE_LSB+PHASE_W-1:PHASE_LSB];
	assign bank_addr   = base_q + BANK_AW'(t_q);
	// oldest window sample sits at write pointer minus avail
	assign ring_rd_idx = slot0_q + t_q[RING_AW-1:0];

	// ------------------------------------------------------------------
	// control state
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= STEP_FETCH;
			ratio_q     <= RATIO_RESET;
			taps_cfg_q  <= TAPS_RESET;
			seen_q      <= SEEN_W'(eff_taps(TAPS_RESET) >> 1);
			pos_q       <= '0;
			t_q         <= '0;
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_TAPS; i++) begin
				ring_q[i] <= '0;
			end
		end else begin
			step_q <= cond_met ? uc.next_t : uc.next_f;

			if (cfg_acc) begin
				if (cfg.index == CFG_STEP_RATIO) begin
					ratio_q <= cfg.data[RATIO_W-1:0];
				end
				if (cfg.index == CFG_TAP_COUNT) begin
					taps_cfg_q <= cfg.data[TAP_W-1:0];
				end
				for (int i = 0; i < MAX_TAPS; i++) begin
					ring_q[i] <= '0;
				end
				seen_q <= restart_seen;
				pos_q  <= '0;
			end else begin
				if (sample_in) begin
					ring_q[seen_q[RING_AW-1:0]] <= item.sample;
					seen_q <= seen_q + SEEN_W'(1);
				end
				if (emit_go) begin
					pos_q <= pos_q + POS_W'(ratio_q);
				end
			end

			if (uc.check) begin
				t_q <= '0;
			end else if (tap_issue) begin
				t_q <= t_q + TAP_W'(1);
			end

			vld_s1 <= tap_issue;
			vld_s2 <= vld_s1;

			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// coefficient bank: one write port, registered read
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (coef_wr) begin
			bank[item.coef_index] <= item.coef_value;
		end
		coef_s1 <= bank[bank_addr];
	end

	// ------------------------------------------------------------------
	// datapath: row base, multiply, accumulate
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (uc.check) begin
			base_q  <= base_full[BANK_AW-1:0];
			slot0_q <= seen_q[RING_AW-1:0] - avail[RING_AW-1:0];
		end
		smp_s1  <= ring_q[ring_rd_idx];
		prod_s2 <= coef_s1 * smp_s1;
		if (uc.check) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// ------------------------------------------------------------------
	// saturate or round-half-up then shift by 14
	// ------------------------------------------------------------------
	assign rnd_full = (acc_q + RND_BIAS) >>> RND_SHIFT;

	always_comb begin
		if (acc_q < ACC_MIN) begin
			res_val  = OUT_MIN;
			res_clip = 1'b1;
		end else if (acc_q > ACC_MAX) begin
			res_val  = OUT_MAX;
			res_clip = 1'b1;
		end else if (rnd_full > RND_TOP) begin
			// rounding carried just past full scale
			res_val  = OUT_MAX;
			res_clip = 1'b1;
		end else begin
			res_val  = rnd_full[SMP_W-1:0];
			res_clip = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			out_sample_q <= res_val;
			clipped_q    <= res_clip;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.out_sample = out_sample_q;
	assign result.clipped    = clipped_q;

endmodule
